// ----- rtl/tsg_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the trapezoid setpoint generator.
// No dependencies; the other RTL files but tsg_if refer to it by scoped names, the testbench imports it.
package tsg_pkg;

	// input opcodes
	localparam logic [2:0] OPC_TICK    = 3'd0;
	localparam logic [2:0] OPC_GOAL    = 3'd1;
	localparam logic [2:0] OPC_PERCENT = 3'd2;
	localparam logic [2:0] OPC_FEEDBK  = 3'd3;
	localparam logic [2:0] OPC_STOP    = 3'd4;

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_POS_LOW   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_POS_HIGH  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SPD_LIMIT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ACC_LIMIT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_CREEP_SPD = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_CREEP_FRC = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_STEP_PER  = 3'd7;

	// configuration reset values
	localparam logic signed [31:0] RST_POS_LOW   = -32'sd6553600;
	localparam logic signed [31:0] RST_POS_HIGH  = 32'sd6553600;
	localparam logic [30:0]        RST_SPD_LIMIT = 31'd65536;
	localparam logic [30:0]        RST_ACC_LIMIT = 31'd65536;
	localparam logic [30:0]        RST_CREEP_SPD = 31'd6554;
	localparam logic [30:0]        RST_TOLERANCE = 31'd66;
	localparam logic [16:0]        RST_CREEP_FRC = 17'd6554;
	localparam logic [15:0]        RST_STEP_PER  = 16'd655;

	// arithmetic constants
	localparam int FRAC_SHIFT   = 16;
	localparam int MUL_STEPS    = 32;   // multiplier operand b width, one bit per cycle
	localparam int DIV_W        = 33;   // divisor width of the serial divider
	localparam int PERCENT_FULL = 6553600;  // 100.0 in Q16.16

	// percent scaling: 6553600 = 25 * 2^18; the /25 splits the value at bit 24
	localparam int PCT_SHIFT       = 18;
	localparam int PCT_STEP        = 671088;    // 2^24 / 25, remainder 16
	localparam int PCT_RECIP       = 42949673;  // ceil(2^30 / 25)
	localparam int PCT_RECIP_SHIFT = 30;

	// datapath micro-operations issued by the controller
	typedef enum logic [4:0] {
		DP_NOP,
		DP_REACH_UPD,
		DP_ARRIVE,
		DP_GOAL_ABS,
		DP_CREEP_START,
		DP_CREEP_SAVE,
		DP_PCT_MUL,
		DP_PCT_DIV,
		DP_PCT_GOAL,
		DP_FEEDBACK,
		DP_STOP,
		DP_DV_MUL,
		DP_SL_MUL,
		DP_CS_MUL,
		DP_BRK_DIV,
		DP_BRAKE,
		DP_SPEED,
		DP_STEP_MUL,
		DP_STEP_ADD,
		DP_EMIT
	} tsg_op_t;

	typedef struct packed {
		logic    take;   // input word accepted this cycle
		tsg_op_t op;
	} tsg_cmd_t;

	typedef struct packed {
		logic mul_busy;
		logic div_busy;
		logic reached;
		logic arrive;    // goal distance below tolerance
	} tsg_stat_t;

endpackage

// ----- rtl/tsg_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces for request and result words.
// No dependencies.
interface tsg_req_if;
	logic              valid;
	logic              ready;
	logic [2:0]        opcode;
	logic signed [31:0] operand_value;
	modport source (output valid, output opcode, output operand_value, input ready);
	modport sink   (input valid, input opcode, input operand_value, output ready);
endinterface

interface tsg_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] command_position;
	logic signed [31:0] command_speed;
	logic               goal_reached;
	modport source (output valid, output command_position, output command_speed,
		output goal_reached, input ready);
	modport sink   (input valid, input command_position, input command_speed,
		input goal_reached, output ready);
endinterface

// ----- rtl/tsg_mul.sv -----
`timescale 1ns / 1ps
// Serial shift-add multiplier, one bit of operand b per cycle.
// Depends on tsg_pkg for the operand b width.
module tsg_mul #(
	parameter int A_W = 33
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [A_W-1:0]                     a,
	input  logic [tsg_pkg::MUL_STEPS-1:0]      b,
	output logic                               busy,
	output logic [A_W+tsg_pkg::MUL_STEPS-1:0]  prod
);
	localparam int BW = tsg_pkg::MUL_STEPS;
	localparam int CW = $clog2(BW + 1);

	logic [A_W-1:0] a_q;
	logic [A_W-1:0] hi_q;
	logic [BW-1:0]  lo_q;
	logic [CW-1:0]  cnt_q;
	logic           busy_q;
	logic [A_W:0]   sum;

	// partial sum for the current multiplier bit
	assign sum = {1'b0, hi_q} + (lo_q[0] ? {1'b0, a_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CW'(1);
			if (cnt_q == CW'(BW - 1)) busy_q <= 1'b0;
		end
	end

	// product shifts right as bits of b are consumed
	always_ff @(posedge clk) begin
		if (start) begin
			a_q  <= a;
			hi_q <= '0;
			lo_q <= b;
		end else if (busy_q) begin
			hi_q <= sum[A_W:1];
			lo_q <= {sum[0], lo_q[BW-1:1]};
		end
	end

	assign busy = busy_q;
	assign prod = {hi_q, lo_q};
endmodule

// ----- rtl/tsg_div.sv -----
`timescale 1ns / 1ps
// Serial restoring divider, one quotient bit per cycle.
// Depends on tsg_pkg for the divisor width.
module tsg_div #(
	parameter int N_W = 65
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [N_W-1:0]              dividend,
	input  logic [tsg_pkg::DIV_W-1:0]   divisor,
	output logic                        busy,
	output logic [N_W-1:0]              quot
);
	localparam int DW = tsg_pkg::DIV_W;
	localparam int CW = $clog2(N_W + 1);

	logic [DW-1:0]  rem_q;
	logic [DW-1:0]  d_q;
	logic [N_W-1:0] quo_q;
	logic [CW-1:0]  cnt_q;
	logic           busy_q;
	logic [DW:0]    shifted;
	logic [DW:0]    trial;
	logic           ge;

	// trial subtract of the divisor from the shifted remainder
	assign shifted = {rem_q, quo_q[N_W-1]};
	assign trial   = shifted - {1'b0, d_q};
	assign ge      = !trial[DW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CW'(1);
			if (cnt_q == CW'(N_W - 1)) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			d_q   <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? trial[DW-1:0] : shifted[DW-1:0];
			quo_q <= {quo_q[N_W-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign quot = quo_q;
endmodule

// ----- rtl/tsg_dp.sv -----
`timescale 1ns / 1ps
// Datapath: configuration, axis state, result register, serial multiplier and divider.
// Depends on tsg_pkg, tsg_mul and tsg_div.
module tsg_dp #(
	parameter int VALUE_BITS = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              wr_en,
	input  logic [tsg_pkg::CFG_IDX_W-1:0]     wr_index,
	input  logic [31:0]                       wr_data,
	input  logic signed [31:0]                operand_value,
	input  tsg_pkg::tsg_cmd_t                 cmd,
	output tsg_pkg::tsg_stat_t                stat,
	output logic signed [31:0]                command_position,
	output logic signed [31:0]                command_speed,
	output logic                              goal_reached
);
	localparam int VB = VALUE_BITS;
	localparam int MA = (VB + 1 > 33) ? VB + 1 : 33;
	localparam int PW = MA + tsg_pkg::MUL_STEPS;
	localparam int WS = PW + 2;
	localparam int FS = tsg_pkg::FRAC_SHIFT;
	localparam logic signed [WS-1:0] VMAX = {{(WS-VB+1){1'b0}}, {(VB-1){1'b1}}};
	localparam logic signed [WS-1:0] VMIN = ~VMAX;

	// configuration
	logic signed [31:0] low_q, high_q;
	logic [30:0]        sl_q, acc_q, cs_q, tol_q;
	logic [16:0]        cf_q;
	logic [15:0]        sp_q;

	// axis state
	logic                 started_q, reached_q;
	logic signed [VB-1:0] pp_q, ps_q, goal_q, setp_q, plan_q, creep_q, brake_q;
	logic signed [31:0]   v_q;
	logic [30:0]          dv_q;
	logic [61:0]          sl2_q;
	logic                 diff_neg_q;

	// result register
	logic signed [31:0] pos_out_q, spd_out_q;
	logic               reach_out_q;

	// serial units
	logic          mul_start, div_start, mul_busy, div_busy;
	logic [MA-1:0] mul_a;
	logic [tsg_pkg::MUL_STEPS-1:0] mul_b;
	logic [PW-1:0] prod, quot, div_n;
	logic [tsg_pkg::DIV_W-1:0] div_d;

	// wide views
	logic signed [WS-1:0] low_w, high_w, pp_w, ps_w, goal_w, setp_w, plan_w, creep_w;
	logic signed [WS-1:0] brake_w, tol_w, sl_w, cs_w, v_w, span_w, dist_w, dmag;
	logic signed [WS-1:0] pfrac_w, quot_w, dv_w, vmag, spanmag;
	logic signed [62:0]   diff;
	logic [62:0]          diff_mag;
	logic [30:0]          acc1;
	logic signed [WS-1:0] spd_t, pct_g;

	// percent quotient pieces
	logic [44:0]          pct_n;
	logic [25:0]          pct_x;
	logic [40:0]          pct_hi;
	logic [51:0]          pct_xm;
	logic [40:0]          pct_hi_q;
	logic [21:0]          pct_lo_q;
	logic [41:0]          pct_q;
	logic signed [WS-1:0] pct_q_w;

	function automatic logic signed [WS-1:0] sat_w(input logic signed [WS-1:0] x);
		if (x > VMAX) return VMAX;
		if (x < VMIN) return VMIN;
		return x;
	endfunction

	function automatic logic signed [WS-1:0] mag_w(input logic signed [WS-1:0] x);
		return (x < 0) ? -x : x;
	endfunction

	function automatic logic signed [WS-1:0] from_mag(input logic neg,
			input logic signed [WS-1:0] m);
		return neg ? sat_w(-m) : sat_w(m);
	endfunction

	// clamp against limits without saturation (result path)
	function automatic logic signed [WS-1:0] lim_w(input logic signed [WS-1:0] x,
			input logic signed [WS-1:0] lo, input logic signed [WS-1:0] hi);
		if (x < lo) return lo;
		if (x > hi) return hi;
		return x;
	endfunction

	assign low_w   = WS'(low_q);
	assign high_w  = WS'(high_q);
	assign pp_w    = WS'(pp_q);
	assign ps_w    = WS'(ps_q);
	assign goal_w  = WS'(goal_q);
	assign setp_w  = WS'(setp_q);
	assign plan_w  = WS'(plan_q);
	assign creep_w = WS'(creep_q);
	assign brake_w = WS'(brake_q);
	assign tol_w   = WS'($signed({1'b0, tol_q}));
	assign sl_w    = WS'($signed({1'b0, sl_q}));
	assign cs_w    = WS'($signed({1'b0, cs_q}));
	assign dv_w    = WS'($signed({1'b0, dv_q}));
	assign v_w     = WS'(v_q);
	assign span_w  = high_w - low_w;
	assign vmag    = mag_w(v_w);
	assign spanmag = mag_w(span_w);
	assign dist_w  = goal_w - pp_w;
	assign dmag    = mag_w(dist_w);
	assign pfrac_w = WS'($signed({1'b0, prod[PW-1:FS]}));
	assign quot_w  = WS'($signed({1'b0, quot}));

	// braking distance numerator: speed_limit^2 - creep_speed^2
	assign diff     = $signed({1'b0, sl2_q}) - $signed({1'b0, prod[61:0]});
	assign diff_mag = (diff < 0) ? 63'(-diff) : 63'(diff);
	assign acc1     = (acc_q == '0) ? 31'd1 : acc_q;

	// percent quotient: drop 2^18, then n/25 = hi*(2^24/25) + (16*hi + lo)/25,
	// the last term by reciprocal multiply (exact for values below 2^30)
	assign pct_n   = prod[tsg_pkg::PCT_SHIFT +: 45];
	assign pct_x   = {1'b0, pct_n[44:24], 4'b0} + {2'b0, pct_n[23:0]};
	assign pct_hi  = {20'b0, pct_n[44:24]} * 41'(tsg_pkg::PCT_STEP);
	assign pct_xm  = {26'b0, pct_x} * 52'(tsg_pkg::PCT_RECIP);
	assign pct_q   = {1'b0, pct_hi_q} + {20'b0, pct_lo_q};
	assign pct_q_w = WS'($signed({1'b0, pct_q}));

	// percent goal: low + signed share of the span
	assign pct_g = low_w + from_mag((v_q < 0) != (span_w < 0), pct_q_w);

	// speed planning for a moving tick
	always_comb begin
		logic                 up;
		logic signed [WS-1:0] cur_m, toward, away, sv_cs, sv_sl;
		up     = goal_w > pp_w;
		cur_m  = mag_w(ps_w);
		toward = up ? dv_w : -dv_w;
		away   = -toward;
		sv_cs  = from_mag(!up, cs_w);
		sv_sl  = from_mag(!up, sl_w);
		if (brake_w > 0 && dmag < brake_w) begin
			if (cur_m > cs_w) begin
				spd_t = sat_w(ps_w + away);
				if (mag_w(spd_t) < cs_w) spd_t = sv_cs;
			end else begin
				spd_t = sat_w(ps_w + toward);
				if (mag_w(spd_t) > cs_w) spd_t = sv_cs;
			end
		end else if (cur_m < sl_w) begin
			if (cur_m < cs_w) spd_t = sv_cs;
			else spd_t = sat_w(ps_w + toward);
			if (mag_w(spd_t) > sl_w) spd_t = sv_sl;
		end else begin
			spd_t = sat_w(ps_w + away);
			if (mag_w(spd_t) < sl_w) spd_t = sv_sl;
		end
	end

	// operand selection for the serial units
	always_comb begin
		mul_start = 1'b1;
		mul_a     = '0;
		mul_b     = '0;
		case (cmd.op)
			tsg_pkg::DP_CREEP_START: begin
				mul_a = MA'(dmag);
				mul_b = 32'(cf_q);
			end
			tsg_pkg::DP_PCT_MUL: begin
				mul_a = MA'(vmag);
				mul_b = spanmag[31:0];
			end
			tsg_pkg::DP_DV_MUL: begin
				mul_a = MA'(acc_q);
				mul_b = 32'(sp_q);
			end
			tsg_pkg::DP_SL_MUL: begin
				mul_a = MA'(sl_q);
				mul_b = 32'(sl_q);
			end
			tsg_pkg::DP_CS_MUL: begin
				mul_a = MA'(cs_q);
				mul_b = 32'(cs_q);
			end
			tsg_pkg::DP_STEP_MUL: begin
				mul_a = MA'(mag_w(plan_w));
				mul_b = 32'(sp_q);
			end
			default: mul_start = 1'b0;
		endcase
	end

	// divider runs only for the braking distance
	always_comb begin
		div_start = 1'b0;
		div_n     = PW'(diff_mag);
		div_d     = {1'b0, acc1, 1'b0};
		case (cmd.op)
			tsg_pkg::DP_BRK_DIV: div_start = 1'b1;
			default: ;
		endcase
	end

	tsg_mul #(.A_W(MA)) u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start), .a(mul_a), .b(mul_b),
		.busy(mul_busy), .prod(prod)
	);

	tsg_div #(.N_W(PW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_n),
		.divisor(div_d), .busy(div_busy), .quot(quot)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q  <= tsg_pkg::RST_POS_LOW;
			high_q <= tsg_pkg::RST_POS_HIGH;
			sl_q   <= tsg_pkg::RST_SPD_LIMIT;
			acc_q  <= tsg_pkg::RST_ACC_LIMIT;
			cs_q   <= tsg_pkg::RST_CREEP_SPD;
			tol_q  <= tsg_pkg::RST_TOLERANCE;
			cf_q   <= tsg_pkg::RST_CREEP_FRC;
			sp_q   <= tsg_pkg::RST_STEP_PER;
		end else if (wr_en) begin
			case (wr_index)
				tsg_pkg::CFG_POS_LOW:   low_q  <= wr_data;
				tsg_pkg::CFG_POS_HIGH:  high_q <= wr_data;
				tsg_pkg::CFG_SPD_LIMIT: sl_q   <= wr_data[30:0];
				tsg_pkg::CFG_ACC_LIMIT: acc_q  <= wr_data[30:0];
				tsg_pkg::CFG_CREEP_SPD: cs_q   <= wr_data[30:0];
				tsg_pkg::CFG_TOLERANCE: tol_q  <= wr_data[30:0];
				tsg_pkg::CFG_CREEP_FRC: cf_q   <= wr_data[16:0];
				tsg_pkg::CFG_STEP_PER:  sp_q   <= wr_data[15:0];
				default: ;
			endcase
		end
	end

	// axis state updates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q <= 1'b0;
			reached_q <= 1'b1;
			pp_q      <= '0;
			ps_q      <= '0;
			goal_q    <= '0;
			setp_q    <= '0;
			plan_q    <= '0;
			creep_q   <= '0;
		end else begin
			case (cmd.op)
				tsg_pkg::DP_REACH_UPD: reached_q <= dmag < tol_w;
				tsg_pkg::DP_ARRIVE: begin
					reached_q <= 1'b1;
					plan_q    <= '0;
					setp_q    <= pp_q;
				end
				tsg_pkg::DP_GOAL_ABS: begin
					if (v_w < low_w) goal_q <= VB'(sat_w(low_w));
					else if (v_w > high_w) goal_q <= VB'(sat_w(high_w));
					else goal_q <= VB'(sat_w(v_w));
				end
				tsg_pkg::DP_PCT_GOAL: begin
					if (pct_g < low_w) goal_q <= VB'(sat_w(low_w));
					else if (pct_g > high_w) goal_q <= VB'(sat_w(high_w));
					else goal_q <= VB'(sat_w(pct_g));
				end
				tsg_pkg::DP_CREEP_SAVE: creep_q <= VB'(sat_w(pfrac_w));
				tsg_pkg::DP_FEEDBACK: begin
					if (!started_q) begin
						started_q <= 1'b1;
						pp_q      <= VB'(sat_w(v_w));
						goal_q    <= VB'(sat_w(v_w));
						setp_q    <= VB'(sat_w(v_w));
						ps_q      <= '0;
					end else begin
						pp_q <= setp_q;
						ps_q <= plan_q;
					end
				end
				tsg_pkg::DP_STOP:  goal_q <= pp_q;
				tsg_pkg::DP_SPEED: plan_q <= VB'(spd_t);
				tsg_pkg::DP_STEP_ADD:
					setp_q <= VB'(sat_w(setp_w + from_mag(plan_w < 0, pfrac_w)));
				default: ;
			endcase
		end
	end

	// scratch registers of the tick and percent sequences and the latched operand
	always_ff @(posedge clk) begin
		if (cmd.take) v_q <= operand_value;
		case (cmd.op)
			tsg_pkg::DP_SL_MUL:  dv_q <= prod[FS +: 31];
			tsg_pkg::DP_CS_MUL:  sl2_q <= prod[61:0];
			tsg_pkg::DP_BRK_DIV: diff_neg_q <= diff < 0;
			tsg_pkg::DP_BRAKE:
				brake_q <= VB'(sat_w(from_mag(diff_neg_q, quot_w) + creep_w));
			tsg_pkg::DP_PCT_DIV: begin
				pct_hi_q <= pct_hi;
				pct_lo_q <= pct_xm[tsg_pkg::PCT_RECIP_SHIFT +: 22];
			end
			default: ;
		endcase
	end

	// result register
	always_ff @(posedge clk) begin
		case (cmd.op)
			tsg_pkg::DP_ARRIVE: begin
				pos_out_q   <= 32'(lim_w(pp_w, low_w, high_w));
				spd_out_q   <= '0;
				reach_out_q <= 1'b1;
			end
			tsg_pkg::DP_EMIT: begin
				pos_out_q   <= 32'(lim_w(setp_w, low_w, high_w));
				spd_out_q   <= plan_w[31:0];
				reach_out_q <= 1'b0;
			end
			default: ;
		endcase
	end

	assign stat.mul_busy = mul_busy;
	assign stat.div_busy = div_busy;
	assign stat.reached  = reached_q;
	assign stat.arrive   = dmag < tol_w;

	assign command_position = pos_out_q;
	assign command_speed    = spd_out_q;
	assign goal_reached     = reach_out_q;
endmodule

// ----- rtl/tsg_ctrl.sv -----
`timescale 1ns / 1ps
// Controller: sequences datapath operations per opcode and owns the handshakes.
// Depends on tsg_pkg.
module tsg_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic [2:0]         in_opcode,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  tsg_pkg::tsg_stat_t stat,
	output tsg_pkg::tsg_cmd_t  cmd
);
	typedef enum logic [4:0] {
		S_IDLE,
		S_TICK,
		S_W_DV,
		S_W_SL,
		S_W_CS,
		S_W_BDIV,
		S_SPEED,
		S_STEP,
		S_W_STEP,
		S_EMIT,
		S_GOAL,
		S_CREEP,
		S_W_CREEP,
		S_PCT,
		S_W_PMUL,
		S_W_PDIV,
		S_FEEDBK,
		S_STOP
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;
	logic   out_load;

	assign in_ready = state_q == S_IDLE;
	assign out_free = !out_valid_q || out_ready;
	assign out_load = cmd.op == tsg_pkg::DP_ARRIVE || cmd.op == tsg_pkg::DP_EMIT;

	// next state and datapath command
	always_comb begin
		state_d  = state_q;
		cmd.take = 1'b0;
		cmd.op   = tsg_pkg::DP_NOP;
		case (state_q)
			S_IDLE: begin
				cmd.take = in_valid;
				if (in_valid) begin
					case (in_opcode)
						tsg_pkg::OPC_TICK:    state_d = S_TICK;
						tsg_pkg::OPC_GOAL:    state_d = S_GOAL;
						tsg_pkg::OPC_PERCENT: state_d = S_PCT;
						tsg_pkg::OPC_FEEDBK:  state_d = S_FEEDBK;
						tsg_pkg::OPC_STOP:    state_d = S_STOP;
						default:              state_d = S_IDLE;
					endcase
				end
			end
			S_TICK: begin
				if (stat.reached) begin
					cmd.op  = tsg_pkg::DP_REACH_UPD;
					state_d = S_IDLE;
				end else if (stat.arrive) begin
					if (out_free) begin
						cmd.op  = tsg_pkg::DP_ARRIVE;
						state_d = S_IDLE;
					end
				end else begin
					cmd.op  = tsg_pkg::DP_DV_MUL;
					state_d = S_W_DV;
				end
			end
			S_W_DV: if (!stat.mul_busy) begin
				cmd.op  = tsg_pkg::DP_SL_MUL;
				state_d = S_W_SL;
			end
			S_W_SL: if (!stat.mul_busy) begin
				cmd.op  = tsg_pkg::DP_CS_MUL;
				state_d = S_W_CS;
			end
			S_W_CS: if (!stat.mul_busy) begin
				cmd.op  = tsg_pkg::DP_BRK_DIV;
				state_d = S_W_BDIV;
			end
			S_W_BDIV: if (!stat.div_busy) begin
				cmd.op  = tsg_pkg::DP_BRAKE;
				state_d = S_SPEED;
			end
			S_SPEED: begin
				cmd.op  = tsg_pkg::DP_SPEED;
				state_d = S_STEP;
			end
			S_STEP: begin
				cmd.op  = tsg_pkg::DP_STEP_MUL;
				state_d = S_W_STEP;
			end
			S_W_STEP: if (!stat.mul_busy) begin
				cmd.op  = tsg_pkg::DP_STEP_ADD;
				state_d = S_EMIT;
			end
			S_EMIT: if (out_free) begin
				cmd.op  = tsg_pkg::DP_EMIT;
				state_d = S_IDLE;
			end
			S_GOAL: begin
				cmd.op  = tsg_pkg::DP_GOAL_ABS;
				state_d = S_CREEP;
			end
			S_CREEP: begin
				cmd.op  = tsg_pkg::DP_CREEP_START;
				state_d = S_W_CREEP;
			end
			S_W_CREEP: if (!stat.mul_busy) begin
				cmd.op  = tsg_pkg::DP_CREEP_SAVE;
				state_d = S_IDLE;
			end
			S_PCT: begin
				cmd.op  = tsg_pkg::DP_PCT_MUL;
				state_d = S_W_PMUL;
			end
			S_W_PMUL: if (!stat.mul_busy) begin
				cmd.op  = tsg_pkg::DP_PCT_DIV;
				state_d = S_W_PDIV;
			end
			S_W_PDIV: if (!stat.div_busy) begin
				cmd.op  = tsg_pkg::DP_PCT_GOAL;
				state_d = S_CREEP;
			end
			S_FEEDBK: begin
				cmd.op  = tsg_pkg::DP_FEEDBACK;
				state_d = S_IDLE;
			end
			S_STOP: begin
				cmd.op  = tsg_pkg::DP_STOP;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state and result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
endmodule

// ----- rtl/trapezoid_setpoint_generator_unit.sv -----
`timescale 1ns / 1ps
// Top level of the trapezoid setpoint generator: controller plus datapath.
// Depends on tsg_pkg, tsg_if, tsg_ctrl and tsg_dp.
//
// Single-axis trapezoidal setpoint generator in signed Q16.16. Each request word
// is one item: goal, percent goal, feedback and stop update the axis and give no
// result; a tick gives at most one result word. One item is processed at a time.
// An absolute goal and a percent goal both rely on the serial multiplier; the
// scaling by 1/100 of a percent goal is a reciprocal multiply. A moving tick runs
// four serial multiplies and one division for the braking distance, the divider
// producing one quotient bit per cycle over max(VALUE_BITS+1,33)+32 bits (65 at
// the default). A finished result waits in an output register; the next request
// is taken meanwhile, and a later tick stalls only when its own result has to be
// loaded.
module trapezoid_setpoint_generator_unit #(
	parameter int VALUE_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [tsg_pkg::CFG_IDX_W-1:0] wr_index,
	input  logic [31:0]                   wr_data,
	tsg_req_if.sink                       request,
	tsg_rsp_if.source                     result
);
	tsg_pkg::tsg_cmd_t  cmd;
	tsg_pkg::tsg_stat_t stat;

	tsg_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(request.valid),
		.in_opcode(request.opcode),
		.in_ready(request.ready),
		.out_valid(result.valid),
		.out_ready(result.ready),
		.stat(stat),
		.cmd(cmd)
	);

	tsg_dp #(.VALUE_BITS(VALUE_BITS)) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data),
		.operand_value(request.operand_value),
		.cmd(cmd),
		.stat(stat),
		.command_position(result.command_position),
		.command_speed(result.command_speed),
		.goal_reached(result.goal_reached)
	);
endmodule

// ----- rtl/tsg_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for the setpoint generator, bound to the top level.
// Depends on tsg_pkg and trapezoid_setpoint_generator_unit.
module tsg_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               req_valid,
	input logic               req_ready,
	input logic [2:0]         req_opcode,
	input logic               rsp_valid,
	input logic               rsp_ready,
	input logic signed [31:0] rsp_position,
	input logic signed [31:0] rsp_speed,
	input logic               rsp_reached
);
	// a stalled result word holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_position)
			&& $stable(rsp_speed) && $stable(rsp_reached))
		else $error("result word changed while stalled");

	// an arrival result always commands zero speed
	a_arrive_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_reached |-> rsp_speed == 32'sd0)
		else $error("arrival result with nonzero speed");

	// every defined opcode, once taken, drops ready in the cycle after
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req_opcode <= tsg_pkg::OPC_STOP |=> !req_ready)
		else $error("request taken while previous word still in work");
endmodule

bind trapezoid_setpoint_generator_unit tsg_checker u_tsg_checker (
	.clk(clk),
	.arst_n(arst_n),
	.req_valid(request.valid),
	.req_ready(request.ready),
	.req_opcode(request.opcode),
	.rsp_valid(result.valid),
	.rsp_ready(result.ready),
	.rsp_position(result.command_position),
	.rsp_speed(result.command_speed),
	.rsp_reached(result.goal_reached)
);

// ----- test/trapezoid_setpoint_generator_unit_tb.sv -----
`timescale 1ns / 1ps
// Testbench for trapezoid_setpoint_generator_unit: random and directed request words
// with a built-in axis predictor and a scoreboard. Depends on tsg_pkg, tsg_if and the RTL.
module trapezoid_setpoint_generator_unit_tb;
	import tsg_pkg::*;

	localparam int IDLE_LIMIT  = 20000;
	localparam int SETTLE_CYC  = 400;
	localparam int HOLD_CYC    = 3000;
	localparam int PHASE_WORDS = 205;

	typedef struct packed {
		logic [31:0] position;
		logic [31:0] speed;
		logic        arrived;
	} motion_word_t;

	// Axis predictor plus the queue of motion words still owed by the block
	class setpoint_scoreboard;
		longint lo, hi, creep_dist;
		longint unsigned spd_lim, acc_lim, creep_spd, tol, cfrac, period;
		bit started, reached;
		longint pres_pos, pres_spd, goal, setp, plan_spd;
		motion_word_t owed_q[$];
		int errors, matched, arrivals;

		function new();
			lo = RST_POS_LOW; hi = RST_POS_HIGH;
			spd_lim = RST_SPD_LIMIT; acc_lim = RST_ACC_LIMIT; creep_spd = RST_CREEP_SPD;
			tol = RST_TOLERANCE; cfrac = RST_CREEP_FRC; period = RST_STEP_PER;
			started = 0; reached = 1;
			pres_pos = 0; pres_spd = 0; goal = 0; setp = 0; plan_spd = 0; creep_dist = 0;
			errors = 0; matched = 0; arrivals = 0;
		endfunction

		function longint sat(longint a);
			if (a > 64'sd2147483647) return 64'sd2147483647;
			if (a < -64'sd2147483648) return -64'sd2147483648;
			return a;
		endfunction

		function longint unsigned mag(longint a);
			return (a < 0) ? longint'(-a) : longint'(a);
		endfunction

		function longint unsigned mulfrac(longint unsigned m, longint unsigned p);
			logic [127:0] prod;
			prod = ({64'd0, m} * {64'd0, p}) >> FRAC_SHIFT;
			if (prod[127:64] != 0) return 64'hFFFF_FFFF_FFFF_FFFF;
			return prod[63:0];
		endfunction

		function longint from_mag(bit neg, longint unsigned m);
			if (neg) return (m >= 64'd2147483648) ? -64'sd2147483648 : -longint'(m);
			return (m > 64'd2147483647) ? 64'sd2147483647 : longint'(m);
		endfunction

		function longint clamp_out(longint p);
			if (p < lo) return lo;
			if (p > hi) return hi;
			return p;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
			case (idx)
				CFG_POS_LOW:   lo = longint'(signed'(data));
				CFG_POS_HIGH:  hi = longint'(signed'(data));
				CFG_SPD_LIMIT: spd_lim = data[30:0];
				CFG_ACC_LIMIT: acc_lim = data[30:0];
				CFG_CREEP_SPD: creep_spd = data[30:0];
				CFG_TOLERANCE: tol = data[30:0];
				CFG_CREEP_FRC: cfrac = data[16:0];
				CFG_STEP_PER:  period = data[15:0];
				default: ;
			endcase
		endfunction

		function void set_goal(longint g);
			longint unsigned d;
			if (g < lo) goal = sat(lo);
			else if (g > hi) goal = sat(hi);
			else goal = sat(g);
			d = (goal >= pres_pos) ? longint'(goal - pres_pos) : longint'(pres_pos - goal);
			creep_dist = from_mag(0, mulfrac(d, cfrac));
		endfunction

		function void tick();
			longint unsigned d, cur_m, acc2, t_m;
			longint dv, diff, brake, t, step;
			bit fwd;
			motion_word_t w;
			d = (goal >= pres_pos) ? longint'(goal - pres_pos) : longint'(pres_pos - goal);
			cur_m = mag(pres_spd);
			if (reached) begin
				reached = (d < tol);
				return;
			end
			// arrival: park on the measured position
			if (d < tol) begin
				reached = 1;
				plan_spd = 0;
				setp = pres_pos;
				w.position = 32'(clamp_out(setp));
				w.speed = '0;
				w.arrived = 1'b1;
				owed_q = {owed_q, w};
				return;
			end
			fwd = (goal > pres_pos);
			dv = longint'(mulfrac(acc_lim, period));
			diff = longint'(spd_lim * spd_lim) - longint'(creep_spd * creep_spd);
			acc2 = 2 * ((acc_lim != 0) ? acc_lim : 1);
			brake = sat(sat(diff / longint'(acc2)) + creep_dist);
			// speed ramp: brake toward creep, else ramp up or down toward the limit
			if (brake > 0 && d < longint'(brake)) begin
				if (cur_m > creep_spd) begin
					t = sat(pres_spd + (fwd ? -dv : dv));
					if (mag(t) < creep_spd) t = from_mag(!fwd, creep_spd);
				end else begin
					t = sat(pres_spd + (fwd ? dv : -dv));
					if (mag(t) > creep_spd) t = from_mag(!fwd, creep_spd);
				end
			end else if (cur_m < spd_lim) begin
				if (cur_m < creep_spd) t = from_mag(!fwd, creep_spd);
				else t = sat(pres_spd + (fwd ? dv : -dv));
				if (mag(t) > spd_lim) t = from_mag(!fwd, spd_lim);
			end else begin
				t = sat(pres_spd + (fwd ? -dv : dv));
				if (mag(t) < spd_lim) t = from_mag(!fwd, spd_lim);
			end
			plan_spd = t;
			t_m = mulfrac(mag(t), period);
			step = from_mag(t < 0, t_m);
			setp = sat(setp + step);
			w.position = 32'(clamp_out(setp));
			w.speed = 32'(plan_spd);
			w.arrived = 1'b0;
			owed_q = {owed_q, w};
		endfunction

		// note one accepted request word
		function void note_word(logic [2:0] op, logic [31:0] val);
			longint v, span;
			longint unsigned q;
			v = longint'(signed'(val));
			case (op)
				OPC_TICK: tick();
				OPC_GOAL: set_goal(v);
				OPC_PERCENT: begin
					span = hi - lo;
					q = (mag(v) * mag(span)) / PERCENT_FULL;
					set_goal(lo + from_mag((v < 0) != (span < 0), q));
				end
				OPC_FEEDBK: begin
					if (!started) begin
						started = 1;
						pres_pos = sat(v);
						goal = pres_pos;
						setp = pres_pos;
						pres_spd = 0;
					end else begin
						pres_pos = setp;
						pres_spd = plan_spd;
					end
				end
				OPC_STOP: goal = pres_pos;
				default: ;
			endcase
		endfunction

		// compare one accepted result word against the oldest owed one
		function void check_word(motion_word_t got);
			motion_word_t exp_w;
			if (owed_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("ERROR: unexpected word pos=%0d spd=%0d arr=%0b",
						$signed(got.position), $signed(got.speed), got.arrived);
				return;
			end
			exp_w = owed_q.pop_front();
			if (got !== exp_w) begin
				errors++;
				if (errors <= 10)
					$display("ERROR: pos exp %0d got %0d, spd exp %0d got %0d, arr exp %0b got %0b",
						$signed(exp_w.position), $signed(got.position),
						$signed(exp_w.speed), $signed(got.speed), exp_w.arrived, got.arrived);
			end else begin
				matched++;
				if (got.arrived) arrivals++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic wr_en = 0;
	logic [CFG_IDX_W-1:0] wr_index = '0;
	logic [31:0] wr_data = '0;
	tsg_req_if req();
	tsg_rsp_if rsp();

	setpoint_scoreboard sb = new();
	bit hold_req = 0;
	bit no_gaps = 0;
	int words_sent = 0;
	int idle_cycles = 0;

	trapezoid_setpoint_generator_unit dut (
		.clk(clk), .arst_n(arst_n), .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
		.request(req), .result(rsp)
	);

	always #5 clk = ~clk;

	initial begin
		req.valid = 0;
		req.opcode = OPC_TICK;
		req.operand_value = '0;
		rsp.ready = 0;
	end

	// receiver: random stalls, stall-free stretches and one long hold-off on request
	always @(negedge clk) begin
		if (hold_req) begin
			rsp.ready = 0;
			repeat (HOLD_CYC) @(negedge clk);
			hold_req = 0;
		end else if (no_gaps) begin
			rsp.ready = 1;
		end else begin
			rsp.ready = ($urandom_range(0, 99) < 70);
		end
	end

	// result check and inactivity watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp.valid && rsp.ready)
				sb.check_word({rsp.command_position, rsp.command_speed, rsp.goal_reached});
			if ((rsp.valid && rsp.ready) || (req.valid && req.ready)) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic send_word(input logic [2:0] op, input logic [31:0] val);
		int g;
		g = pick_gap();
		if (g > 0) begin
			req.valid = 0;
			repeat (g) @(negedge clk);
		end
		req.valid = 1;
		req.opcode = op;
		req.operand_value = val;
		do @(posedge clk); while (!req.ready);
		sb.note_word(op, val);
		words_sent++;
		@(negedge clk);
	endtask

	// drain everything owed, then let any silent work finish before writes
	task automatic settle();
		req.valid = 0;
		while (sb.owed_q.size() != 0) @(negedge clk);
		repeat (SETTLE_CYC) @(negedge clk);
	endtask

	task automatic write_all(input longint vals[8]);
		for (int i = 0; i < 8; i++) begin
			wr_en = 1;
			wr_index = i[CFG_IDX_W-1:0];
			wr_data = vals[i][31:0];
			sb.write_reg(wr_index, wr_data);
			@(negedge clk);
		end
		wr_en = 0;
	endtask

	function automatic logic [31:0] pick_operand(logic [2:0] op);
		int r;
		r = $urandom_range(0, 99);
		if (op == OPC_PERCENT)
			return (r < 85) ? $urandom_range(0, 120 * 65536) : $urandom();
		if (r < 55) return $urandom_range(0, 40 * 65536) - 20 * 65536;
		if (r < 75) return $urandom_range(0, 400 * 65536) - 200 * 65536;
		return $urandom();
	endfunction

	// mostly tick/feedback motion sequences, some goal changes and noise
	task automatic random_phase(input int n, input bit with_hold);
		int r;
		logic [2:0] op;
		for (int i = 0; i < n; i++) begin
			if (i % 60 == 0) no_gaps = ($urandom_range(0, 2) == 0);
			if (with_hold && i == n / 2) hold_req = 1;
			r = $urandom_range(0, 99);
			if (r < 50) op = OPC_TICK;
			else if (r < 75) op = OPC_FEEDBK;
			else if (r < 85) op = OPC_GOAL;
			else if (r < 91) op = OPC_PERCENT;
			else if (r < 96) op = OPC_STOP;
			else op = 3'($urandom_range(5, 7));
			send_word(op, pick_operand(op));
		end
		no_gaps = 0;
	endtask

	initial begin
		longint cfg[8];
		repeat (12) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed: startup, goal extremes, percent goals, stop and unused opcodes
		send_word(OPC_TICK, 32'd0);
		send_word(OPC_FEEDBK, 32'h0001_8000);
		send_word(OPC_GOAL, 32'h7FFF_FFFF);
		send_word(OPC_TICK, 32'd0);
		send_word(OPC_TICK, 32'd0);
		send_word(OPC_FEEDBK, 32'hFFFF_FFFF);
		send_word(OPC_TICK, 32'd0);
		send_word(OPC_GOAL, 32'h8000_0000);
		send_word(OPC_TICK, 32'd0);
		send_word(OPC_FEEDBK, 32'd0);
		send_word(OPC_TICK, 32'd0);
		send_word(OPC_PERCENT, 32'd0);
		send_word(OPC_TICK, 32'd0);
		send_word(OPC_PERCENT, 32'd6553600);
		send_word(OPC_TICK, 32'd0);
		send_word(OPC_PERCENT, -32'sd3276800);
		send_word(OPC_PERCENT, 32'h7FFF_FFFF);
		send_word(OPC_PERCENT, 32'h8000_0000);
		send_word(OPC_STOP, 32'h5555_AAAA);
		send_word(OPC_TICK, 32'd0);
		send_word(OPC_TICK, 32'd0);
		send_word(3'd5, 32'd1);
		send_word(3'd6, 32'd2);
		send_word(3'd7, 32'd3);
		send_word(OPC_GOAL, 32'd0);
		random_phase(PHASE_WORDS / 2, 0);
		settle();

		// brisk axis that arrives often
		cfg = '{-655360, 655360, 262144, 524288, 32768, 655, 16384, 6554};
		write_all(cfg);
		random_phase(PHASE_WORDS, 1);
		settle();

		// widest limits and most registers at their top values
		cfg = '{-2147483648, 2147483647, 2147483647, 2147483647, 2147483647,
			2147483647, 65536, 65535};
		write_all(cfg);
		random_phase(PHASE_WORDS, 0);
		settle();

		// bottom values, crossed limits, zero acceleration and period
		cfg = '{65536000, -65536000, 0, 0, 0, 0, 0, 0};
		write_all(cfg);
		random_phase(PHASE_WORDS / 2, 0);
		settle();

		// finest period and acceleration
		cfg = '{-6553600, 6553600, 65536, 1, 6554, 66, 6554, 1};
		write_all(cfg);
		random_phase(PHASE_WORDS / 2, 0);
		settle();

		// random moderate settings
		cfg = '{-longint'($urandom_range(1, 50) * 65536), longint'($urandom_range(1, 50) * 65536),
			longint'($urandom_range(0, 20 * 65536)), longint'($urandom_range(1, 40 * 65536)),
			longint'($urandom_range(0, 65536)), longint'($urandom_range(0, 8192)),
			longint'($urandom_range(0, 65536)), longint'($urandom_range(1, 65535))};
		write_all(cfg);
		random_phase(PHASE_WORDS, 0);

		settle();
		$display("Run covered %0d request words over six register settings.", words_sent);
		$display("Matched %0d motion words, %0d of them arrivals.", sb.matched, sb.arrivals);
		if (sb.errors == 0 && sb.owed_q.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("Mismatches: %0d, words still owed: %0d", sb.errors, sb.owed_q.size());
			$display("DONE: errors detected");
		end
		$finish;
	end
endmodule
